// ===== src/owoi_pkg.sv =====
// Shared types, widths and constants of the omni-wheel odometry integrator.
`timescale 1ns / 1ps
`default_nettype none

package owoi_pkg;

  // Field and register widths.
  localparam int COEF_W    = 18;
  localparam int NUM_COEF  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int SPEED_W   = 16;
  localparam int TIME_W    = 20;
  localparam int ANGLE_W   = 16;
  localparam int RATE_W    = 16;
  localparam int POS_W     = 32;
  localparam int POS_SUM_W = POS_W + 1;
  localparam int VEL_W     = 24;
  localparam int VEL_SHIFT = 8;

  // Sine and cosine: Q1.15, quarter-wave lookup on a binary angle.
  localparam int TRIG_W       = 16;
  localparam int TRIG_MAG_MAX = 32767;
  localparam int FRAC_W       = 14;
  localparam int QUARTER_TURN = 16384;

  // Constants of the Taylor series that builds the quarter-wave table.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int SERIES_Q    = 30;
  localparam int ROUND_SHIFT = 15;

  // Shared multiplier and accumulator.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 61;
  localparam int ROT_W   = 41;
  localparam int SPLIT_W = ROT_W - MUL_A_W;

  // Displacement scaling: divide by 2^15 and then by one million.
  localparam int DISP_SHIFT   = 15;
  localparam int DISP_DIVISOR = 1000000;
  localparam int DIV_NUM_W    = ACC_W - DISP_SHIFT;
  localparam int DIV_MAG_W    = DIV_NUM_W - 1;
  localparam int DIV_Q_W      = 26;
  // The remainder before the correction step stays below twice the divisor.
  localparam int DIV_REM_W    = 21;
  localparam int DIV_CNT_W    = 3;
  localparam int DIV_STEPS    = 6;

  // Reciprocal of the divisor scaled by 2^46; the quotient estimate is low by at most one.
  localparam int RECIP_SHIFT = 46;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DISP_DIVISOR));
  localparam int DIV_SPLIT   = RECIP_SHIFT / 2;
  localparam int DIV_PROD_W  = DIV_SPLIT + RECIP_W;

  // Reset values of the coefficient registers.
  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
    18'sd0, -18'sd1135, 18'sd1135, 18'sd1311, -18'sd655, -18'sd655
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CX1 = 3'd0,
    REG_CX2 = 3'd1,
    REG_CX3 = 3'd2,
    REG_CY1 = 3'd3,
    REG_CY2 = 3'd4,
    REG_CY3 = 3'd5
  } reg_index_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [3:0] {
    MS_NONE,
    MS_C0W1,
    MS_C1W2,
    MS_C2W3,
    MS_C3W1,
    MS_C4W2,
    MS_C5W3,
    MS_VXC,
    MS_VYS,
    MS_VXS,
    MS_VYC,
    MS_PXH,
    MS_PXL,
    MS_PYH,
    MS_PYL
  } mul_sel_t;

  // What is done with the product registered in the previous cycle.
  typedef enum logic [3:0] {
    AO_NONE,
    AO_LOAD,
    AO_ADD,
    AO_FIN_VX,
    AO_FIN_VY,
    AO_FIN_PX,
    AO_FIN_PY,
    AO_LOAD_HI,
    AO_FIN_NX,
    AO_FIN_NY
  } acc_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     div_start;
    logic     writeback;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
  } dpath_status_t;

  // Saturate an accumulator value to the velocity range.
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-VEL_W:0] top;
    top = v[ACC_W-1:VEL_W-1];
    if ((&top) || !(|top)) begin
      return v[VEL_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VEL_W-1){1'b1}}};
    end
  endfunction

  // Saturate a position sum to the 32-bit signed range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_SUM_W-1:0] v);
    if (v[POS_SUM_W-1] == v[POS_W-1]) begin
      return v[POS_W-1:0];
    end else if (v[POS_SUM_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/owoi_div.sv =====
// Two-lane divider by one million, by reciprocal multiplication, that turns the scaled products into displacements.
`timescale 1ns / 1ps
`default_nettype none

module owoi_div
  import owoi_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  logic signed [ACC_W-1:0] num_x,
  input  wire  logic signed [ACC_W-1:0] num_y,
  output logic                         busy,
  output logic signed [DIV_Q_W:0]      quo_x,
  output logic signed [DIV_Q_W:0]      quo_y
);

  // Steps of one division, counted down from the start.
  localparam logic [DIV_CNT_W-1:0] STEP_LO   = DIV_CNT_W'(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] STEP_HI   = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [DIV_CNT_W-1:0] STEP_EST  = DIV_CNT_W'(DIV_STEPS - 2);
  localparam logic [DIV_CNT_W-1:0] STEP_BACK = DIV_CNT_W'(DIV_STEPS - 3);
  localparam logic [DIV_CNT_W-1:0] STEP_REM  = DIV_CNT_W'(DIV_STEPS - 4);
  localparam logic [DIV_CNT_W-1:0] STEP_FIX  = DIV_CNT_W'(DIV_STEPS - 5);

  logic [DIV_CNT_W-1:0]   cnt;
  logic signed [ACC_W-1:0] lane_num [2];
  logic signed [DIV_Q_W:0] lane_quo [2];

  assign lane_num[0] = num_x;
  assign lane_num[1] = num_y;
  assign quo_x = lane_quo[0];
  assign quo_y = lane_quo[1];
  assign busy = (cnt != '0);

  // Step counter shared by both lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= STEP_LO;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  genvar g;
  for (g = 0; g < 2; g++) begin : g_lane
    logic [DIV_NUM_W-1:0]  shifted;
    logic                  neg;
    logic [DIV_MAG_W-1:0]  mag;
    logic [DIV_MAG_W-1:0]  mag_r;
    logic                  neg_r;
    logic [DIV_SPLIT-1:0]  op_a;
    logic [RECIP_W-1:0]    op_b;
    logic [DIV_PROD_W-1:0] prod;
    logic [DIV_PROD_W-1:0] part;
    logic [DIV_PROD_W-1:0] est_sum;
    logic [DIV_Q_W-1:0]    q_est;
    logic [DIV_REM_W-1:0]  rem;
    logic [DIV_Q_W-1:0]    quo;

    // Floor division of a negative value works on its one's complement.
    always_comb begin
      shifted = lane_num[g][ACC_W-1:DISP_SHIFT];
      neg     = shifted[DIV_NUM_W-1];
      mag     = neg ? ~shifted[DIV_MAG_W-1:0] : shifted[DIV_MAG_W-1:0];
      est_sum = prod + (part >> DIV_SPLIT);
    end

    // The multiplier forms the low and high halves of the reciprocal product,
    // then the estimate times the divisor.
    always_comb begin
      case (cnt)
        STEP_LO: begin
          op_a = mag_r[DIV_SPLIT-1:0];
          op_b = RECIP;
        end
        STEP_HI: begin
          op_a = DIV_SPLIT'(mag_r[DIV_MAG_W-1:DIV_SPLIT]);
          op_b = RECIP;
        end
        STEP_BACK: begin
          op_a = DIV_SPLIT'(DISP_DIVISOR);
          op_b = RECIP_W'(q_est);
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end

    // Estimate, remainder and the single correction step.
    always_ff @(posedge clk) begin
      if (start) begin
        mag_r <= mag;
        neg_r <= neg;
      end
      prod <= op_a * op_b;
      case (cnt)
        STEP_HI:  part  <= prod;
        STEP_EST: q_est <= est_sum[DIV_SPLIT +: DIV_Q_W];
        STEP_REM: rem   <= mag_r[DIV_REM_W-1:0] - prod[DIV_REM_W-1:0];
        STEP_FIX: quo   <= (rem >= DIV_REM_W'(DISP_DIVISOR)) ? q_est + 1'b1 : q_est;
        default: ;
      endcase
    end

    assign lane_quo[g] = neg_r ? $signed(~{1'b0, quo}) : $signed({1'b0, quo});
  end

endmodule

`default_nettype wire

// ===== src/owoi_dpath.sv =====
// Datapath: coefficients, sine table, shared multiplier, accumulator and position.
`timescale 1ns / 1ps
`default_nettype none

module owoi_dpath
  import owoi_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire  logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire  logic [COEF_W-1:0]        cfg_data,
  input  wire  logic signed [SPEED_W-1:0] wheel_speed_one,
  input  wire  logic signed [SPEED_W-1:0] wheel_speed_two,
  input  wire  logic signed [SPEED_W-1:0] wheel_speed_three,
  input  wire  logic [TIME_W-1:0]        elapsed_time,
  input  wire  logic [ANGLE_W-1:0]       heading_angle,
  input  wire  logic signed [RATE_W-1:0] yaw_rate_in,
  input  wire  ctrl_cmd_t                cmd,
  output dpath_status_t                  status,
  output logic signed [POS_W-1:0]        position_x,
  output logic signed [POS_W-1:0]        position_y,
  output logic signed [VEL_W-1:0]        velocity_x,
  output logic signed [VEL_W-1:0]        velocity_y,
  output logic [ANGLE_W-1:0]             heading_out,
  output logic signed [RATE_W-1:0]       yaw_rate_out
);

  localparam int AW    = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

  logic signed [COEF_W-1:0]  coef [NUM_COEF];
  logic signed [SPEED_W-1:0] spd1, spd2, spd3;
  logic [TIME_W-1:0]         dt;
  logic [ANGLE_W-1:0]        head;
  logic signed [RATE_W-1:0]  yaw;

  logic [TRIG_W-2:0]         sine_rom [SINE_TABLE_DEPTH];
  logic [ANGLE_W-1:0]        ang [2];
  logic signed [TRIG_W-1:0]  trig [2];

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   sum_w, diff_w, vel_w;
  logic signed [VEL_W-1:0]   vx, vy;
  logic signed [ROT_W-1:0]   rot_x, rot_y;
  logic signed [ACC_W-1:0]   disp_x, disp_y;
  logic signed [DIV_Q_W:0]   quo_x, quo_y;
  logic signed [POS_SUM_W-1:0] pos_sum_x, pos_sum_y;
  logic                      div_busy;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= COEF_RESET[i];
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CX1: coef[0] <= $signed(cfg_data);
        REG_CX2: coef[1] <= $signed(cfg_data);
        REG_CX3: coef[2] <= $signed(cfg_data);
        REG_CY1: coef[3] <= $signed(cfg_data);
        REG_CY2: coef[4] <= $signed(cfg_data);
        REG_CY3: coef[5] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Capture of the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      spd1 <= wheel_speed_one;
      spd2 <= wheel_speed_two;
      spd3 <= wheel_speed_three;
      dt   <= elapsed_time;
      head <= heading_angle;
      yaw  <= yaw_rate_in;
    end
  end

  // Quarter-wave sine table, evaluated at elaboration by a thirteen-term series.
  genvar k;
  for (k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] X0 = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    localparam logic [63:0] X2 = (X0 * X0) >> SERIES_Q;
    localparam logic [63:0] T1  = ((X0  * X2) >> SERIES_Q) / 6;
    localparam logic [63:0] T2  = ((T1  * X2) >> SERIES_Q) / 20;
    localparam logic [63:0] T3  = ((T2  * X2) >> SERIES_Q) / 42;
    localparam logic [63:0] T4  = ((T3  * X2) >> SERIES_Q) / 72;
    localparam logic [63:0] T5  = ((T4  * X2) >> SERIES_Q) / 110;
    localparam logic [63:0] T6  = ((T5  * X2) >> SERIES_Q) / 156;
    localparam logic [63:0] T7  = ((T6  * X2) >> SERIES_Q) / 210;
    localparam logic [63:0] T8  = ((T7  * X2) >> SERIES_Q) / 272;
    localparam logic [63:0] T9  = ((T8  * X2) >> SERIES_Q) / 342;
    localparam logic [63:0] T10 = ((T9  * X2) >> SERIES_Q) / 420;
    localparam logic [63:0] T11 = ((T10 * X2) >> SERIES_Q) / 506;
    localparam logic [63:0] T12 = ((T11 * X2) >> SERIES_Q) / 600;
    localparam logic signed [63:0] S = $signed(X0) - $signed(T1) + $signed(T2)
      - $signed(T3) + $signed(T4) - $signed(T5) + $signed(T6) - $signed(T7)
      + $signed(T8) - $signed(T9) + $signed(T10) - $signed(T11) + $signed(T12);
    localparam logic signed [63:0] SC = (S < 0) ? 64'sd0 : S;
    localparam logic signed [63:0] R  = (SC + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    localparam logic signed [63:0] E  = (R > TRIG_MAG_MAX) ? 64'(TRIG_MAG_MAX) : R;
    assign sine_rom[k] = E[TRIG_W-2:0];
  end

  // Sine and cosine lookups; cosine is the sine a quarter turn ahead.
  assign ang[0] = head;
  assign ang[1] = head + ANGLE_W'(QUARTER_TURN);

  genvar g;
  for (g = 0; g < 2; g++) begin : g_trig
    logic [1:0]              quad;
    logic [FRAC_W-1:0]       frac;
    logic [FRAC_W:0]         u;
    logic [FRAC_W+IDX_W-1:0] scaled;
    logic [IDX_W-1:0]        idx;
    logic [TRIG_W-2:0]       mag;

    always_comb begin
      quad   = ang[g][ANGLE_W-1:FRAC_W];
      frac   = ang[g][FRAC_W-1:0];
      u      = quad[0] ? ((FRAC_W+1)'(QUARTER_TURN) - {1'b0, frac}) : {1'b0, frac};
      scaled = (FRAC_W+IDX_W)'(u * SINE_TABLE_DEPTH);
      idx    = scaled[FRAC_W+IDX_W-1:FRAC_W];
      if (idx >= IDX_W'(SINE_TABLE_DEPTH)) begin
        mag = (TRIG_W-1)'(TRIG_MAG_MAX);
      end else begin
        mag = sine_rom[idx[AW-1:0]];
      end
    end

    always_ff @(posedge clk) begin
      trig[g] <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_sel)
      MS_C0W1: begin mul_a = MUL_A_W'(coef[0]); mul_b = MUL_B_W'(spd1); end
      MS_C1W2: begin mul_a = MUL_A_W'(coef[1]); mul_b = MUL_B_W'(spd2); end
      MS_C2W3: begin mul_a = MUL_A_W'(coef[2]); mul_b = MUL_B_W'(spd3); end
      MS_C3W1: begin mul_a = MUL_A_W'(coef[3]); mul_b = MUL_B_W'(spd1); end
      MS_C4W2: begin mul_a = MUL_A_W'(coef[4]); mul_b = MUL_B_W'(spd2); end
      MS_C5W3: begin mul_a = MUL_A_W'(coef[5]); mul_b = MUL_B_W'(spd3); end
      MS_VXC:  begin mul_a = MUL_A_W'(vx); mul_b = MUL_B_W'(trig[1]); end
      MS_VYS:  begin mul_a = MUL_A_W'(vy); mul_b = MUL_B_W'(trig[0]); end
      MS_VXS:  begin mul_a = MUL_A_W'(vx); mul_b = MUL_B_W'(trig[0]); end
      MS_VYC:  begin mul_a = MUL_A_W'(vy); mul_b = MUL_B_W'(trig[1]); end
      MS_PXH:  begin
        mul_a = $signed(rot_x[ROT_W-1:SPLIT_W]);
        mul_b = $signed(MUL_B_W'(dt));
      end
      MS_PXL:  begin
        mul_a = $signed(MUL_A_W'(rot_x[SPLIT_W-1:0]));
        mul_b = $signed(MUL_B_W'(dt));
      end
      MS_PYH:  begin
        mul_a = $signed(rot_y[ROT_W-1:SPLIT_W]);
        mul_b = $signed(MUL_B_W'(dt));
      end
      MS_PYL:  begin
        mul_a = $signed(MUL_A_W'(rot_y[SPLIT_W-1:0]));
        mul_b = $signed(MUL_B_W'(dt));
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Accumulator arithmetic on the previous product.
  always_comb begin
    sum_w  = acc + ACC_W'(prod);
    diff_w = acc - ACC_W'(prod);
    vel_w  = sum_w >>> VEL_SHIFT;
  end

  // Registered product and accumulator steps.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.acc_op)
      AO_LOAD:    acc    <= ACC_W'(prod);
      AO_ADD:     acc    <= sum_w;
      AO_FIN_VX:  vx     <= sat_vel(vel_w);
      AO_FIN_VY:  vy     <= sat_vel(vel_w);
      AO_FIN_PX:  rot_x  <= diff_w[ROT_W-1:0];
      AO_FIN_PY:  rot_y  <= sum_w[ROT_W-1:0];
      AO_LOAD_HI: acc    <= ACC_W'(prod) <<< SPLIT_W;
      AO_FIN_NX:  disp_x <= sum_w;
      AO_FIN_NY:  disp_y <= sum_w;
      default: ;
    endcase
  end

  // Displacement division for both axes.
  owoi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num_x (disp_x),
    .num_y (disp_y),
    .busy  (div_busy),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  assign status.div_busy = div_busy;

  // Position update and result registers.
  always_comb begin
    pos_sum_x = POS_SUM_W'(position_x) + POS_SUM_W'(quo_x);
    pos_sum_y = POS_SUM_W'(position_y) + POS_SUM_W'(quo_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_x <= '0;
      position_y <= '0;
    end else if (cmd.writeback) begin
      position_x <= sat_pos(pos_sum_x);
      position_y <= sat_pos(pos_sum_y);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.writeback) begin
      velocity_x   <= vx;
      velocity_y   <= vy;
      heading_out  <= head;
      yaw_rate_out <= yaw;
    end
  end

endmodule

`default_nettype wire

// ===== src/owoi_ctrl.sv =====
// Controller: sequences the multiplier steps, the division and the result writeback.
`timescale 1ns / 1ps
`default_nettype none

module owoi_ctrl
  import owoi_pkg::*;
(
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire           out_stall,
  output ctrl_cmd_t     cmd,
  input  dpath_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_WAIT
  } state_t;

  localparam logic [3:0] LAST_STEP = 4'd14;

  state_t     state;
  logic [3:0] step;
  logic       slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // State, step counter and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.writeback) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CALC;
            step  <= '0;
          end
        end
        S_CALC: begin
          if (step == LAST_STEP) begin
            state <= S_DIV;
          end else begin
            step <= 4'(step + 1'b1);
          end
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (!status.div_busy && slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command decode. Each step but the last issues one product; each step but the first consumes the one before.
  always_comb begin
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.div_start = (state == S_DIV);
    cmd.writeback = (state == S_WAIT) && !status.div_busy && slot_free;
    cmd.mul_sel   = MS_NONE;
    cmd.acc_op    = AO_NONE;
    if (state == S_CALC) begin
      case (step)
        4'd0:  begin cmd.mul_sel = MS_C0W1; cmd.acc_op = AO_NONE;    end
        4'd1:  begin cmd.mul_sel = MS_C1W2; cmd.acc_op = AO_LOAD;    end
        4'd2:  begin cmd.mul_sel = MS_C2W3; cmd.acc_op = AO_ADD;     end
        4'd3:  begin cmd.mul_sel = MS_C3W1; cmd.acc_op = AO_FIN_VX;  end
        4'd4:  begin cmd.mul_sel = MS_C4W2; cmd.acc_op = AO_LOAD;    end
        4'd5:  begin cmd.mul_sel = MS_C5W3; cmd.acc_op = AO_ADD;     end
        4'd6:  begin cmd.mul_sel = MS_VXC;  cmd.acc_op = AO_FIN_VY;  end
        4'd7:  begin cmd.mul_sel = MS_VYS;  cmd.acc_op = AO_LOAD;    end
        4'd8:  begin cmd.mul_sel = MS_VXS;  cmd.acc_op = AO_FIN_PX;  end
        4'd9:  begin cmd.mul_sel = MS_VYC;  cmd.acc_op = AO_LOAD;    end
        4'd10: begin cmd.mul_sel = MS_PXH;  cmd.acc_op = AO_FIN_PY;  end
        4'd11: begin cmd.mul_sel = MS_PXL;  cmd.acc_op = AO_LOAD_HI; end
        4'd12: begin cmd.mul_sel = MS_PYH;  cmd.acc_op = AO_FIN_NX;  end
        4'd13: begin cmd.mul_sel = MS_PYL;  cmd.acc_op = AO_LOAD_HI; end
        4'd14: begin cmd.mul_sel = MS_NONE; cmd.acc_op = AO_FIN_NY;  end
        default: begin cmd.mul_sel = MS_NONE; cmd.acc_op = AO_NONE;  end
      endcase
    end
  end

  // A writeback always presents a result in the next cycle.
  a_wb_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.writeback |=> out_valid)
    else $error("writeback did not raise the result valid");

  // An accepted item blocks further input and cannot be written back at once.
  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !cmd.writeback))
    else $error("input not held off after an accepted item");

  // The divider is never restarted while it is working.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  // A start always makes the divider busy in the next cycle.
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");

endmodule

`default_nettype wire

// ===== src/omni_wheel_odometry_integrator_top.sv =====
// Top level of the three-wheel omni-drive odometry integrator.
`timescale 1ns / 1ps
`default_nettype none

// Each item carries three wheel speeds, the elapsed time and the heading; the block
// forms body velocities from the six coefficient registers, rotates them into the
// world frame with a quarter-wave sine table, scales them by the elapsed time and
// adds them to the saturating world position, returning one result per item. An
// accepted item is captured, its products pass through one shared 25x21 multiplier,
// the divider is loaded, both axes are divided by one million in parallel through a
// reciprocal multiplication and one correction step, and the result is written back
// once the divider is done and the output slot is free; the block then returns to idle.
// A finished result waits in the output registers while the next item is already
// being worked on; the user must write coefficients only while the block is idle,
// and the block itself does not enforce this.
module omni_wheel_odometry_integrator_top
  import owoi_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire  logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire  logic [COEF_W-1:0]        cfg_data,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  logic signed [SPEED_W-1:0] wheel_speed_one,
  input  wire  logic signed [SPEED_W-1:0] wheel_speed_two,
  input  wire  logic signed [SPEED_W-1:0] wheel_speed_three,
  input  wire  logic [TIME_W-1:0]        elapsed_time,
  input  wire  logic [ANGLE_W-1:0]       heading_angle,
  input  wire  logic signed [RATE_W-1:0] yaw_rate_in,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic signed [POS_W-1:0]        position_x,
  output logic signed [POS_W-1:0]        position_y,
  output logic signed [VEL_W-1:0]        velocity_x,
  output logic signed [VEL_W-1:0]        velocity_y,
  output logic [ANGLE_W-1:0]             heading_out,
  output logic signed [RATE_W-1:0]       yaw_rate_out
);

  ctrl_cmd_t     cmd;
  dpath_status_t status;

  // Sequencer.
  owoi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and storage.
  owoi_dpath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .wheel_speed_one   (wheel_speed_one),
    .wheel_speed_two   (wheel_speed_two),
    .wheel_speed_three (wheel_speed_three),
    .elapsed_time      (elapsed_time),
    .heading_angle     (heading_angle),
    .yaw_rate_in       (yaw_rate_in),
    .cmd               (cmd),
    .status            (status),
    .position_x        (position_x),
    .position_y        (position_y),
    .velocity_x        (velocity_x),
    .velocity_y        (velocity_y),
    .heading_out       (heading_out),
    .yaw_rate_out      (yaw_rate_out)
  );

endmodule

`default_nettype wire
